// ----- hw/rtl/ghe_pkg.sv -----
// Shared types, constants and the arctangent table of the heading estimator.
package ghe_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int AtanLen = 24;
	localparam int CordicN = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;
	localparam int IterW = $clog2(AtanLen);
	localparam logic [IterW-1:0] IterLast = IterW'(CordicN - 1);

	localparam logic [15:0] ThrReset = 16'd200;
	localparam logic [31:0] ThrSqReset = 32'd40000;
	localparam logic signed [36:0] CordicGain = 37'sd652032874;
	localparam logic [31:0] AngHalfTurn = 32'h8000_0000;

	localparam int QDepth = 2;
	localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW = $clog2(QDepth + 1);

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic               moved;
		logic               emit;
		logic               fix_ok;
	} ghe_item_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_DIFF,
		F_SQX,
		F_SQY,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_NORM,
		B_VEC,
		B_HEAD,
		B_ROT,
		B_QUAT,
		B_DONE
	} back_state_t;

	function automatic logic [31:0] atan_tab(input logic [IterW-1:0] i);
		logic [31:0] t;
		case (i)
			5'd0: t = 32'h20000000;
			5'd1: t = 32'h12E4051E;
			5'd2: t = 32'h09FB385B;
			5'd3: t = 32'h051111D4;
			5'd4: t = 32'h028B0D43;
			5'd5: t = 32'h0145D7E1;
			5'd6: t = 32'h00A2F61E;
			5'd7: t = 32'h00517C55;
			5'd8: t = 32'h0028BE53;
			5'd9: t = 32'h00145F2F;
			5'd10: t = 32'h000A2F98;
			5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6;
			5'd13: t = 32'h000145F3;
			5'd14: t = 32'h0000A2FA;
			5'd15: t = 32'h0000517D;
			5'd16: t = 32'h000028BE;
			5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A30;
			5'd19: t = 32'h00000518;
			5'd20: t = 32'h0000028C;
			5'd21: t = 32'h00000146;
			5'd22: t = 32'h000000A3;
			5'd23: t = 32'h00000051;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

endpackage

// ----- hw/rtl/ghe_front.sv -----
// Front end: takes a fix, applies the planar move test and tracks the reference position.
module ghe_front import ghe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [15:0]       cfg_wdata,
	input  logic              s_valid,
	output logic              s_ready,
	input  logic [95:0]       s_data,
	input  logic              q_full,
	output logic              q_push,
	output ghe_item_t         q_item
);

	front_state_t       state_q, state_nx;
	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [31:0] ref_x_q, ref_y_q;
	logic signed [32:0] dx_q, dy_q;
	logic [32:0]        adx, ady;
	logic               big_q;
	logic [31:0]        sqx_q, sqy_q;
	logic               ready_q;
	logic [15:0]        thr_q;
	logic [31:0]        thr_sq_q;
	logic               moved;

	assign adx = dx_q[32] ? (~dx_q + 33'd1) : dx_q;
	assign ady = dy_q[32] ? (~dy_q + 33'd1) : dy_q;
	assign moved = big_q || (({1'b0, sqx_q} + {1'b0, sqy_q}) > {1'b0, thr_sq_q});

	always_comb begin
		state_nx = state_q;
		case (state_q)
			F_IDLE: if (s_valid) state_nx = F_DIFF;
			F_DIFF: state_nx = F_SQX;
			F_SQX: state_nx = F_SQY;
			F_SQY: state_nx = F_PUSH;
			F_PUSH: if (!q_full) state_nx = F_IDLE;
			default: state_nx = F_IDLE;
		endcase
	end

	always_comb begin
		s_ready = (state_q == F_IDLE);
		q_push = (state_q == F_PUSH) && !q_full;
		q_item.px = px_q;
		q_item.py = py_q;
		q_item.pz = pz_q;
		q_item.dx = dx_q;
		q_item.dy = dy_q;
		q_item.moved = moved;
		q_item.emit = ready_q || moved;
		q_item.fix_ok = (px_q != 32'sd0) && (py_q != 32'sd0) && (pz_q != 32'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ref_x_q <= '0;
			ref_y_q <= '0;
			ready_q <= 1'b0;
			thr_q <= ThrReset;
			thr_sq_q <= ThrSqReset;
		end else begin
			state_q <= state_nx;
			if (cfg_wen) thr_q <= cfg_wdata;
			thr_sq_q <= {16'd0, thr_q} * {16'd0, thr_q};
			if (q_push && moved) begin
				ref_x_q <= px_q;
				ref_y_q <= py_q;
				ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (s_valid) begin
					px_q <= s_data[31:0];
					py_q <= s_data[63:32];
					pz_q <= s_data[95:64];
				end
			end
			F_DIFF: begin
				dx_q <= {px_q[31], px_q} - {ref_x_q[31], ref_x_q};
				dy_q <= {py_q[31], py_q} - {ref_y_q[31], ref_y_q};
			end
			F_SQX: begin
				big_q <= (adx[32:16] != 17'd0) || (ady[32:16] != 17'd0);
				sqx_q <= {16'd0, adx[15:0]} * {16'd0, adx[15:0]};
			end
			F_SQY: sqy_q <= {16'd0, ady[15:0]} * {16'd0, ady[15:0]};
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/ghe_queue.sv -----
// Short queue of classified fixes between the front and back ends.
module ghe_queue import ghe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ghe_item_t push_item,
	output logic      full,
	input  logic      pop,
	output ghe_item_t pop_item,
	output logic      empty
);

	ghe_item_t         mem_q [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0]  count_q;

	assign full = (count_q == QCntW'(QDepth));
	assign empty = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ----- hw/rtl/ghe_back.sv -----
// Back end: iterative CORDIC for heading and half-angle quaternion, and the output register.
module ghe_back import ghe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	output logic         q_pop,
	input  ghe_item_t    q_item,
	output logic         m_valid,
	input  logic         m_ready,
	output logic [143:0] m_data,
	output logic         m_user
);

	back_state_t        state_q, state_nx;
	ghe_item_t          item_q;
	logic signed [36:0] x_q, y_q;
	logic [31:0]        ang_q;
	logic [IterW-1:0]   iter_q;
	logic signed [15:0] head_q, qz_q, qw_q;
	logic [143:0]       out_data_q;
	logic               out_fix_q;
	logic               out_valid_q;

	logic signed [36:0] dx37, dy37, ys, xs, x_nx, y_nx, ax, ay;
	logic [31:0]        tab, ang_nx, ang_rnd;
	logic [32:0]        mag_or;
	logic               dir;
	logic               load_out;

	function automatic logic signed [15:0] q15_sat(input logic signed [36:0] v);
		logic signed [36:0] vr;
		logic signed [21:0] r;
		vr = v + 37'sd16384;
		r = vr[36:15];
		if (r > 22'sd32767) return 16'sh7FFF;
		if (r < -22'sd32768) return 16'sh8000;
		return r[15:0];
	endfunction

	assign dx37 = {{4{q_item.dx[32]}}, q_item.dx};
	assign dy37 = {{4{q_item.dy[32]}}, q_item.dy};
	assign ax = x_q[36] ? -x_q : x_q;
	assign ay = y_q[36] ? -y_q : y_q;
	assign mag_or = ax[32:0] | ay[32:0];

	assign ys = y_q >>> iter_q;
	assign xs = x_q >>> iter_q;
	assign tab = atan_tab(iter_q);
	assign dir = (state_q == B_VEC) ? (!y_q[36] && (y_q != 37'sd0)) : ang_q[31];
	assign x_nx = dir ? x_q + ys : x_q - ys;
	assign y_nx = dir ? y_q - xs : y_q + xs;
	assign ang_nx = dir ? ang_q + tab : ang_q - tab;
	assign ang_rnd = ang_q + 32'h0000_8000;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) state_nx = q_item.moved ? B_NORM : B_DONE;
			end
			B_NORM: if (mag_or[32]) state_nx = B_VEC;
			B_VEC: if (iter_q == IterLast) state_nx = B_HEAD;
			B_HEAD: state_nx = B_ROT;
			B_ROT: if (iter_q == IterLast) state_nx = B_QUAT;
			B_QUAT: state_nx = B_DONE;
			B_DONE: if (!out_valid_q || m_ready) state_nx = B_IDLE;
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == B_IDLE) && !q_empty;
		load_out = (state_q == B_DONE) && (!out_valid_q || m_ready);
		m_valid = out_valid_q;
		m_data = out_data_q;
		m_user = out_fix_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			head_q <= '0;
			qz_q <= '0;
			qw_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == B_HEAD) head_q <= ang_rnd[31:16];
			if (state_q == B_QUAT) begin
				qw_q <= q15_sat(x_q);
				qz_q <= q15_sat(y_q);
			end
			if (load_out) out_valid_q <= item_q.emit;
			else if (m_valid && m_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					item_q <= q_item;
					if (q_item.dx[32]) begin
						x_q <= -dx37;
						y_q <= -dy37;
						ang_q <= AngHalfTurn;
					end else begin
						x_q <= dx37;
						y_q <= dy37;
						ang_q <= '0;
					end
				end
			end
			B_NORM: begin
				iter_q <= '0;
				if (mag_or[32:24] == 9'd0) begin
					x_q <= x_q <<< 8;
					y_q <= y_q <<< 8;
				end else if (mag_or[32:28] == 5'd0) begin
					x_q <= x_q <<< 4;
					y_q <= y_q <<< 4;
				end else if (mag_or[32:30] == 3'd0) begin
					x_q <= x_q <<< 2;
					y_q <= y_q <<< 2;
				end else if (!mag_or[32]) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			B_VEC, B_ROT: begin
				x_q <= x_nx;
				y_q <= y_nx;
				ang_q <= ang_nx;
				iter_q <= iter_q + 1'b1;
			end
			B_HEAD: begin
				x_q <= CordicGain;
				y_q <= '0;
				ang_q <= {ang_rnd[31], ang_rnd[31:16], 15'd0};
				iter_q <= '0;
			end
			B_DONE: begin
				if (load_out) begin
					out_data_q <= {qw_q, qz_q, head_q, item_q.pz, item_q.py, item_q.px};
					out_fix_q <= item_q.fix_ok;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/gnss_heading_estimator.sv -----
// Top level of the GNSS heading estimator: front end, queue and CORDIC back end.
//
// Each word on the input stream is one position fix. The front end takes a fix through the
// difference from the reference, two squarings and the distance compare, and hands it to a
// two-entry queue, waiting while the queue is full. A fix that clears the distance threshold
// passes the back end through normalising shifts, the vectoring and then the rotating pass
// of one shared iterative CORDIC unit, and rounding and output. Any other fix goes from the
// queue straight to the output stage. That CORDIC unit sets the sustained rate while
// headings are being updated. No output word appears until the first heading has been
// found.
module gnss_heading_estimator import ghe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // pos_x_mm, pos_y_mm, pos_z_mm
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,  // out_x_mm, out_y_mm, out_z_mm, heading_angle, quat_z, quat_w
	output logic         m_axis_tuser   // fix_ok
);

	ghe_item_t push_item, pop_item;
	logic      push, pop, full, empty;

	ghe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.s_data    (s_axis_tdata),
		.q_full    (full),
		.q_push    (push),
		.q_item    (push_item)
	);

	ghe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	ghe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (empty),
		.q_pop   (pop),
		.q_item  (pop_item),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_data  (m_axis_tdata),
		.m_user  (m_axis_tuser)
	);

endmodule
